>>> rtl/checksummed_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Checksummed frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication.
`define CFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// Checksummed frame receiver package
// Types and constants shared by the front end, the event queue and the back end.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_HEAD_BYTE = 2'd0;
  localparam cfg_idx_t CFG_KEY_LIMIT = 2'd1;

  // Register reset values.
  localparam byte_t HEAD_BYTE_RST = 8'hA5;
  localparam byte_t KEY_LIMIT_RST = 8'd36;

  typedef enum logic {
    EV_KEY  = 1'b0,
    EV_RESP = 1'b1
  } event_kind_t;

  // One classified frame, as passed from the front end to the back end.
  typedef struct packed {
    event_kind_t kind;
    byte_t       code;
    byte_t       value;
  } cfr_event_t;

  // Request from the front end into the event queue.
  typedef struct packed {
    logic       push;
    cfr_event_t ev;
  } cfr_push_t;

endpackage

>>> rtl/checksummed_frame_receiver.sv
// A frame's event is written into the event queue, then registered into the result fields, before out_valid rises.
// Throughput: one byte per cycle while the queue has room; the frame check completes
// in the cycle the byte is taken. Input stalls only while the queue is full.
// At most one event per four bytes, buffered in a QUEUE_DEPTH entry queue before the output.
// Reset: head byte 0xA5, key limit 36, window and queue empty; no clearing pass.
// ----------------------------------------------------------------------------
// Checksummed frame receiver
// Deframes a byte stream into checked four-byte frames and reports key events
// and MCU responses.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfr_pkg::byte_t    in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_event_kind,
  output cfr_pkg::byte_t    out_key_index,
  output logic              out_key_pressed,
  output cfr_pkg::byte_t    out_resp_code,
  output cfr_pkg::byte_t    out_resp_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  cfr_pkg::cfg_idx_t cfg_index,
  input  cfr_pkg::byte_t    cfg_data
);
  import cfr_pkg::*;

  cfr_push_t  push_req;
  cfr_event_t q_head;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  cfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push_req   (push_req)
  );

  cfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  cfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_key_index   (out_key_index),
    .out_key_pressed (out_key_pressed),
    .out_resp_code   (out_resp_code),
    .out_resp_status (out_resp_status)
  );

endmodule

>>> rtl/cfr_front.sv
// ----------------------------------------------------------------------------
// Checksummed frame receiver front end
// Holds the configuration registers and the partial-frame window, checks each
// completed frame and pushes a classified event, or resynchronizes on failure.
// ----------------------------------------------------------------------------
module cfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfr_pkg::byte_t    in_rx_byte,
  input  logic              cfg_valid,
  input  cfr_pkg::cfg_idx_t cfg_index,
  input  cfr_pkg::byte_t    cfg_data,
  input  logic              q_full,
  output cfr_pkg::cfr_push_t push_req
);
  import cfr_pkg::*;

  byte_t       head_byte_r;
  byte_t       key_limit_r;
  byte_t       held_r   [3];
  byte_t       held_nxt [3];
  logic [1:0]  held_cnt_r;
  logic [1:0]  held_cnt_nxt;
  logic        accept;
  byte_t       sum;
  logic        frame_ok;
  logic        is_key;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r <= HEAD_BYTE_RST;
      key_limit_r <= KEY_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEAD_BYTE: head_byte_r <= cfg_data;
        CFG_KEY_LIMIT: key_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sum      = held_r[0] + held_r[1] + held_r[2];
  assign frame_ok = (held_r[0] == head_byte_r) && (in_rx_byte == sum);
  assign is_key   = (held_r[1] != '0) && (held_r[1] <= key_limit_r);

  always_comb begin
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    push_req     = '0;
    push_req.ev.kind  = is_key ? EV_KEY : EV_RESP;
    push_req.ev.code  = held_r[1];
    push_req.ev.value = held_r[2];
    if (accept) begin
      if (held_cnt_r != 2'd3) begin
        case (held_cnt_r)
          2'd0:    held_nxt[0] = in_rx_byte;
          2'd1:    held_nxt[1] = in_rx_byte;
          default: held_nxt[2] = in_rx_byte;
        endcase
        held_cnt_nxt = held_cnt_r + 2'd1;
      end else if (frame_ok) begin
        push_req.push = 1'b1;
        held_cnt_nxt  = 2'd0;
      end else if (held_r[1] == head_byte_r) begin
        // Resynchronize on the earliest head byte after the first position.
        held_nxt[0]  = held_r[1];
        held_nxt[1]  = held_r[2];
        held_nxt[2]  = in_rx_byte;
        held_cnt_nxt = 2'd3;
      end else if (held_r[2] == head_byte_r) begin
        held_nxt[0]  = held_r[2];
        held_nxt[1]  = in_rx_byte;
        held_cnt_nxt = 2'd2;
      end else if (in_rx_byte == head_byte_r) begin
        held_nxt[0]  = in_rx_byte;
        held_cnt_nxt = 2'd1;
      end else begin
        held_cnt_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

>>> rtl/cfr_queue.sv
// ----------------------------------------------------------------------------
// Checksummed frame receiver event queue
// Small circular buffer that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "checksummed_frame_receiver_defines.svh"

module cfr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfr_pkg::cfr_push_t  push_req,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output cfr_pkg::cfr_event_t head
);
  import cfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfr_event_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;

  assign push  = push_req.push;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req.ev;
    end
  end

  `CFR_ASSERT_NOW(a_no_overflow, push, !full, "event pushed into a full queue")
  `CFR_ASSERT_NOW(a_no_underflow, pop, !empty, "event popped from an empty queue")
  `CFR_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CNT_W'(1),
    "queue count did not follow a push")
  `CFR_ASSERT_NEXT(a_count_down, pop && !push, count_r == $past(count_r) - CNT_W'(1),
    "queue count did not follow a pop")

endmodule

>>> rtl/cfr_back.sv
// ----------------------------------------------------------------------------
// Checksummed frame receiver back end
// Pops classified events and formats them into the registered result fields.
// ----------------------------------------------------------------------------
module cfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cfr_pkg::cfr_event_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_event_kind,
  output cfr_pkg::byte_t      out_key_index,
  output logic                out_key_pressed,
  output cfr_pkg::byte_t      out_resp_code,
  output cfr_pkg::byte_t      out_resp_status
);
  import cfr_pkg::*;

  logic  out_valid_r;
  logic  out_valid_nxt;
  logic  kind_r;
  byte_t key_index_r;
  logic  key_pressed_r;
  byte_t resp_code_r;
  byte_t resp_status_r;

  // The result register reloads from a waiting event whenever it is empty or being taken.
  assign q_pop         = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_head.kind;
      if (q_head.kind == EV_KEY) begin
        key_index_r   <= q_head.code - 8'd1;
        key_pressed_r <= (q_head.value != '0);
        resp_code_r   <= '0;
        resp_status_r <= '0;
      end else begin
        key_index_r   <= '0;
        key_pressed_r <= 1'b0;
        resp_code_r   <= q_head.code;
        resp_status_r <= q_head.value;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_key_index   = key_index_r;
  assign out_key_pressed = key_pressed_r;
  assign out_resp_code   = resp_code_r;
  assign out_resp_status = resp_status_r;

endmodule
